@@ rtl/core/pce_pkg.sv @@
// Shared constants for the extreme corner search.
// Corner direction signs, corner counts and queue depth. No dependencies.
`timescale 1ns / 1ps

package pce_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int NUM_CORNERS    = 8;
  localparam int ID_BITS        = $clog2(NUM_CORNERS);
  localparam int QUEUE_DEPTH    = 2;

  localparam logic MODE_CUBOID = 1'b0;
  localparam logic MODE_RECT   = 1'b1;

  localparam logic [ID_BITS-1:0] CUBE_LAST_ID = ID_BITS'(NUM_CORNERS - 1);
  localparam logic [ID_BITS-1:0] RECT_LAST_ID = ID_BITS'(3);

  // bit i set: corner i takes the coordinate with a plus sign
  localparam logic [NUM_CORNERS-1:0] CUBE_X_POS = 8'b1011_0010;
  localparam logic [NUM_CORNERS-1:0] CUBE_Y_POS = 8'b1101_0100;
  localparam logic [NUM_CORNERS-1:0] CUBE_Z_POS = 8'b1110_1000;
  localparam logic [NUM_CORNERS-1:0] RECT_X_POS = 8'b0000_1010;
  localparam logic [NUM_CORNERS-1:0] RECT_Z_POS = 8'b0000_1100;
  localparam logic [NUM_CORNERS-1:0] RECT_USED  = 8'b0000_1111;

endpackage

@@ rtl/core/pce_front.sv @@
// Front end: takes points and updates the eight corner candidates in parallel.
// Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_front #(
  parameter int COORD_BITS = pce_pkg::COORD_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            mode_i,
  input  logic                                            accept_i,
  input  logic signed [COORD_BITS-1:0]                    x_i,
  input  logic signed [COORD_BITS-1:0]                    y_i,
  input  logic signed [COORD_BITS-1:0]                    z_i,
  input  logic                                            last_i,
  output logic                                            snap_push_o,
  output logic [pce_pkg::NUM_CORNERS*3*COORD_BITS:0]      snap_o
);
  import pce_pkg::*;

  localparam int DW = COORD_BITS + 2;

  logic                         seeded_q, seeded_d;
  logic signed [COORD_BITS-1:0] bx_q [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] by_q [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] bz_q [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] bx_d [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] by_d [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] bz_d [NUM_CORNERS];

  function automatic logic signed [DW-1:0] term(input logic signed [COORD_BITS-1:0] v,
                                                input logic pos, input logic en);
    logic signed [DW-1:0] e;
    e = {{2{v[COORD_BITS-1]}}, v};
    if (!en) return '0;
    return pos ? e : -e;
  endfunction

  always_comb begin
    logic                  px, py, pz, yen, used, wr;
    logic signed [DW-1:0]  dn, db;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      px   = (mode_i == MODE_RECT) ? RECT_X_POS[i] : CUBE_X_POS[i];
      py   = CUBE_Y_POS[i];
      yen  = (mode_i == MODE_CUBOID);
      pz   = (mode_i == MODE_RECT) ? RECT_Z_POS[i] : CUBE_Z_POS[i];
      used = (mode_i == MODE_CUBOID) || RECT_USED[i];
      dn   = term(x_i, px, 1'b1) + term(y_i, py, yen) + term(z_i, pz, 1'b1);
      db   = term(bx_q[i], px, 1'b1) + term(by_q[i], py, yen) + term(bz_q[i], pz, 1'b1);
      wr   = accept_i && (!seeded_q || (used && (dn > db)));
      bx_d[i] = wr ? x_i : bx_q[i];
      by_d[i] = wr ? y_i : by_q[i];
      bz_d[i] = wr ? z_i : bz_q[i];
      snap_o[(3*i)*COORD_BITS +: COORD_BITS]   = bx_d[i];
      snap_o[(3*i+1)*COORD_BITS +: COORD_BITS] = by_d[i];
      snap_o[(3*i+2)*COORD_BITS +: COORD_BITS] = bz_d[i];
    end
    snap_o[NUM_CORNERS*3*COORD_BITS] = mode_i;
  end

  assign seeded_d    = accept_i ? !last_i : seeded_q;
  assign snap_push_o = accept_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else begin
      seeded_q <= seeded_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      bx_q[i] <= bx_d[i];
      by_q[i] <= by_d[i];
      bz_q[i] <= bz_d[i];
    end
  end

endmodule

@@ rtl/core/pce_queue.sv @@
// Short queue of finished corner sets between front and back end.
// Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  import pce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/pce_back.sv @@
// Back end: walks the corners of the oldest finished set, one result per transaction.
// Depends on pce_pkg.
`timescale 1ns / 1ps

module pce_back #(
  parameter int COORD_BITS = pce_pkg::COORD_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [pce_pkg::NUM_CORNERS*3*COORD_BITS:0]  snap_i,
  input  logic                                        snap_empty_i,
  output logic                                        snap_pop_o,
  input  logic                                        pop_i,
  output logic                                        empty_o,
  output logic [pce_pkg::ID_BITS-1:0]                 corner_id_o,
  output logic signed [COORD_BITS-1:0]                corner_x_o,
  output logic signed [COORD_BITS-1:0]                corner_y_o,
  output logic signed [COORD_BITS-1:0]                corner_z_o,
  output logic                                        final_corner_o
);
  import pce_pkg::*;

  logic [ID_BITS-1:0]           idx_q, idx_d;
  logic [ID_BITS-1:0]           last_id;
  logic signed [COORD_BITS-1:0] cx [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] cy [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] cz [NUM_CORNERS];
  logic                         take;

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      cx[i] = snap_i[(3*i)*COORD_BITS +: COORD_BITS];
      cy[i] = snap_i[(3*i+1)*COORD_BITS +: COORD_BITS];
      cz[i] = snap_i[(3*i+2)*COORD_BITS +: COORD_BITS];
    end
  end

  assign last_id = (snap_i[NUM_CORNERS*3*COORD_BITS] == MODE_RECT) ? RECT_LAST_ID
                                                                     : CUBE_LAST_ID;
  assign empty_o        = snap_empty_i;
  assign take           = pop_i && !snap_empty_i;
  assign final_corner_o = (idx_q == last_id);
  assign snap_pop_o     = take && final_corner_o;
  assign corner_id_o    = idx_q;
  assign corner_x_o     = cx[idx_q];
  assign corner_y_o     = cy[idx_q];
  assign corner_z_o     = cz[idx_q];

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = final_corner_o ? '0 : idx_q + ID_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ rtl/core/point_cloud_extreme_corners.sv @@
// Top level of the extreme corner search over a 3-D point stream.
// Instantiates pce_front, pce_queue and pce_back; depends on pce_pkg.
`timescale 1ns / 1ps

// Points are taken one per clock while full is low; each point updates all
// corner candidates in the same cycle. The point flagged end_of_cloud closes
// the cloud: its corner set goes into a two-entry queue and the candidates rearm
// for the next cloud. The result side then gives one corner per cycle with pop
// high, eight in cuboid or four in rectangle mode, origin first, final_corner_o
// on the last. full rises only while two finished sets wait, so the input
// stalls only when clouds are shorter than the result side takes to drain.
// Mode is sampled per point and, for the count of results, at the last point.
module point_cloud_extreme_corners #(
  parameter int COORD_BITS = pce_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mode_we_i,
  input  logic                         mode_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] x_coord_i,
  input  logic signed [COORD_BITS-1:0] y_coord_i,
  input  logic signed [COORD_BITS-1:0] z_coord_i,
  input  logic                         end_of_cloud_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [pce_pkg::ID_BITS-1:0]  corner_id_o,
  output logic signed [COORD_BITS-1:0] corner_x_o,
  output logic signed [COORD_BITS-1:0] corner_y_o,
  output logic signed [COORD_BITS-1:0] corner_z_o,
  output logic                         final_corner_o
);
  import pce_pkg::*;

  localparam int SNAP_W = NUM_CORNERS * 3 * COORD_BITS + 1;

  logic              mode_q;
  logic              accept;
  logic              snap_push, snap_pop, snap_empty;
  logic [SNAP_W-1:0] snap_in, snap_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CUBOID;
    end else if (mode_we_i) begin
      mode_q <= mode_i;
    end
  end

  assign accept = push && !full;

  pce_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .accept_i    (accept),
    .x_i         (x_coord_i),
    .y_i         (y_coord_i),
    .z_i         (z_coord_i),
    .last_i      (end_of_cloud_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  pce_queue #(.W(SNAP_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (full),
    .pop_i   (snap_pop),
    .data_o  (snap_head),
    .empty_o (snap_empty)
  );

  pce_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_i         (snap_head),
    .snap_empty_i   (snap_empty),
    .snap_pop_o     (snap_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .corner_id_o    (corner_id_o),
    .corner_x_o     (corner_x_o),
    .corner_y_o     (corner_y_o),
    .corner_z_o     (corner_z_o),
    .final_corner_o (final_corner_o)
  );

  a_final_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && final_corner_o) |-> (corner_id_o == CUBE_LAST_ID || corner_id_o == RECT_LAST_ID))
    else $error("final corner with wrong id");

  a_id_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !final_corner_o) |=>
      (!empty && corner_id_o == $past(corner_id_o) + ID_BITS'(1)))
    else $error("corner sequence broken");

  a_cloud_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_cloud_i && empty) |=> (!empty && corner_id_o == '0))
    else $error("closed cloud not queued");

endmodule
